FILE: sv/min_priority_queue_scan_macros.svh
// ----------------------------------------------------------------------------
// min_priority_queue_scan_macros.svh
// Assertion shorthands for the priority queue block, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_SCAN_MACROS_SVH
`define MIN_PRIORITY_QUEUE_SCAN_MACROS_SVH

// same-cycle implication
`define MPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and codes for the unsorted-array min-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int POS_W  = 5;
  localparam int PRIO_W = 16;
  localparam int FILL_W = 7;

  typedef struct packed {
    logic [POS_W-1:0]  robot_row;
    logic [POS_W-1:0]  robot_col;
    logic [POS_W-1:0]  human_row;
    logic [POS_W-1:0]  human_col;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DEQ   = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ENQ   = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

endpackage

FILE: sv/min_priority_queue_scan.sv
// ----------------------------------------------------------------------------
// min_priority_queue_scan
// Min-priority queue held unsorted in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the in_ ports and pulse start while busy is low; the word is
//   taken at that edge. in_command 0 enqueues the carried entry, 1 dequeues
//   the entry of smallest priority (lowest index wins a tie).
//   Output: one result word per command, shown for exactly one cycle with
//   out_valid high. The receiver cannot stall; nothing is ever held back.
//   Timing: enqueue and dequeue-on-empty answer in the next cycle and leave
//   busy low, so one such command may be issued every cycle.
//   A dequeue of N held entries streams the RAM one entry per cycle through
//   its single read port, then writes the last entry into the hole and shows
//   the result; busy stays high from the start edge until the result is
//   shown, and falls in that same cycle.
//   Reset (synchronous, rst_n low) empties the queue and idles the
//   controller. RAM contents are not cleared; only entries below the fill
//   count are ever read.
//   Full queue: an enqueue is dropped and reported as full.
// ----------------------------------------------------------------------------
`include "min_priority_queue_scan_macros.svh"

module min_priority_queue_scan #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ROWS        = 16,
  parameter int COLS        = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic [mpq_pkg::POS_W-1:0]  in_robot_row,
  input  logic [mpq_pkg::POS_W-1:0]  in_robot_col,
  input  logic [mpq_pkg::POS_W-1:0]  in_human_row,
  input  logic [mpq_pkg::POS_W-1:0]  in_human_col,
  input  logic [mpq_pkg::PRIO_W-1:0] in_priority,
  // result channel
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [mpq_pkg::POS_W-1:0]  out_robot_row,
  output logic [mpq_pkg::POS_W-1:0]  out_robot_col,
  output logic [mpq_pkg::POS_W-1:0]  out_human_row,
  output logic [mpq_pkg::POS_W-1:0]  out_human_col,
  output logic [mpq_pkg::PRIO_W-1:0] out_priority,
  output logic [mpq_pkg::FILL_W-1:0] out_fill_count
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Storage: one write port, one registered read port
  // --------------------------------------------------------------------------
  mpq_pkg::entry_t mem [QUEUE_DEPTH];
  mpq_pkg::entry_t rd_data_r;
  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;
  mpq_pkg::entry_t mem_wdata;

  // --------------------------------------------------------------------------
  // Control and scan state
  // --------------------------------------------------------------------------
  mpq_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] issue_idx_r, issue_idx_nxt;   // next address to read
  logic             issue_done_r, issue_done_nxt; // last entry already read
  logic             rd_vld_r, rd_vld_nxt;         // rd_data_r holds a scan word
  logic [IDX_W-1:0] rd_idx_r;                     // its index
  mpq_pkg::entry_t  best_r, best_nxt;             // running minimum
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;

  // result word registers
  logic             out_valid_r, out_valid_nxt;
  mpq_pkg::status_t out_status_r, out_status_nxt;
  mpq_pkg::entry_t  out_entry_r, out_entry_nxt;
  logic [CNT_W-1:0] out_count_r;

  // helpers
  logic [IDX_W-1:0] last_idx;
  logic             take_new;
  mpq_pkg::entry_t  cand;
  logic [IDX_W-1:0] cand_idx;
  mpq_pkg::entry_t  in_entry;
  mpq_pkg::entry_t  sentinel;

  assign last_idx = IDX_W'(count_r - 1'b1);

  assign in_entry.robot_row = in_robot_row;
  assign in_entry.robot_col = in_robot_col;
  assign in_entry.human_row = in_human_row;
  assign in_entry.human_col = in_human_col;
  assign in_entry.prio      = in_priority;

  // empty dequeue answers with the grid size, low bits only
  assign sentinel.robot_row = mpq_pkg::POS_W'(ROWS);
  assign sentinel.robot_col = mpq_pkg::POS_W'(COLS);
  assign sentinel.human_row = mpq_pkg::POS_W'(ROWS);
  assign sentinel.human_col = mpq_pkg::POS_W'(COLS);
  assign sentinel.prio      = '0;

  // first word seeds the minimum; strict less-than keeps the lowest index on ties
  assign take_new = (rd_idx_r == '0) || (rd_data_r.prio < best_r.prio);
  assign cand     = take_new ? rd_data_r : best_r;
  assign cand_idx = take_new ? rd_idx_r  : best_idx_r;

  // --------------------------------------------------------------------------
  // RAM
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[issue_idx_r];
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mpq_pkg::S_IDLE;
      count_r      <= '0;
      issue_idx_r  <= '0;
      issue_done_r <= 1'b1;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      issue_idx_r  <= issue_idx_nxt;
      issue_done_r <= issue_done_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    rd_idx_r     <= issue_idx_r;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_count_r  <= count_nxt;
  end

  // --------------------------------------------------------------------------
  // Next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_idx_nxt  = issue_idx_r;
    issue_done_nxt = issue_done_r;
    rd_vld_nxt     = 1'b0;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    mem_we         = 1'b0;
    mem_waddr      = cand_idx;
    mem_wdata      = rd_data_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = mpq_pkg::STAT_ENQ;
    out_entry_nxt  = '0;

    case (state_r)
      mpq_pkg::S_IDLE: begin
        if (start) begin
          if (in_command == mpq_pkg::CMD_ENQ) begin
            out_valid_nxt = 1'b1;
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              out_status_nxt = mpq_pkg::STAT_FULL;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = count_r[IDX_W-1:0];
              mem_wdata      = in_entry;
              count_nxt      = count_r + 1'b1;
              out_status_nxt = mpq_pkg::STAT_ENQ;
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = mpq_pkg::STAT_EMPTY;
            out_entry_nxt  = sentinel;
          end else begin
            state_nxt      = mpq_pkg::S_SCAN;
            issue_idx_nxt  = '0;
            issue_done_nxt = 1'b0;
          end
        end
      end
      mpq_pkg::S_SCAN: begin
        // read side: one address per cycle up to the tail
        if (!issue_done_r) begin
          rd_vld_nxt = 1'b1;
          if (issue_idx_r == last_idx) begin
            issue_done_nxt = 1'b1;
          end else begin
            issue_idx_nxt = IDX_W'(issue_idx_r + 1'b1);
          end
        end
        // compare side, in the cycle after each read is issued
        if (rd_vld_r) begin
          best_nxt     = cand;
          best_idx_nxt = cand_idx;
          if (rd_idx_r == last_idx) begin
            // tail word is in rd_data_r: move it into the hole
            mem_we         = 1'b1;
            mem_waddr      = cand_idx;
            mem_wdata      = rd_data_r;
            count_nxt      = count_r - 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = mpq_pkg::STAT_DEQ;
            out_entry_nxt  = cand;
            state_nxt      = mpq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mpq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != mpq_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_robot_row  = out_entry_r.robot_row;
  assign out_robot_col  = out_entry_r.robot_col;
  assign out_human_row  = out_entry_r.human_row;
  assign out_human_col  = out_entry_r.human_col;
  assign out_priority   = out_entry_r.prio;
  assign out_fill_count = mpq_pkg::FILL_W'(out_count_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MPQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "fill count overflow")
  `MPQ_ASSERT_IMP(a_result_idle, out_valid_r, state_r == mpq_pkg::S_IDLE, "result while scanning")
  `MPQ_ASSERT_IMP(a_scan_word, rd_vld_r, state_r == mpq_pkg::S_SCAN, "scan word outside scan")
  `MPQ_ASSERT_NXT(a_enq_answer, start && !busy && in_command == mpq_pkg::CMD_ENQ,
    out_valid && (out_status == mpq_pkg::STAT_ENQ || out_status == mpq_pkg::STAT_FULL),
    "enqueue not answered")

endmodule

FILE: dv/min_priority_queue_scan_tb.sv
// ----------------------------------------------------------------------------
// min_priority_queue_scan_tb
// Self-checking bench for the unsorted-array min-priority queue. A driver
// feeds command words from a pending list in random bursts. A model of the
// queue, kept in step with every accepted word, predicts each result word.
// A monitor checks each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module min_priority_queue_scan_tb;

  localparam int QUEUE_DEPTH    = 64;
  localparam int ROWS           = 16;
  localparam int COLS           = 16;
  // the limit sits far above the longest dequeue scan and the longest
  // sender gap, which leaves a wide margin
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_MAX     = 10;

  // one command word as queued for the driver
  typedef struct {
    mpq_pkg::cmd_t   cmd;
    mpq_pkg::entry_t ent;
    bit              wait_drain;  // hold off until every result word is back
  } cmd_word_t;

  // one result word; field order matches the port concatenation below
  typedef struct packed {
    mpq_pkg::status_t           status;
    mpq_pkg::entry_t            ent;
    logic [mpq_pkg::FILL_W-1:0] fill;
  } result_word_t;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       start          = 1'b0;
  logic                       in_command     = 1'b0;
  logic [mpq_pkg::POS_W-1:0]  in_robot_row   = '0;
  logic [mpq_pkg::POS_W-1:0]  in_robot_col   = '0;
  logic [mpq_pkg::POS_W-1:0]  in_human_row   = '0;
  logic [mpq_pkg::POS_W-1:0]  in_human_col   = '0;
  logic [mpq_pkg::PRIO_W-1:0] in_priority    = '0;
  logic                       busy;
  logic                       out_valid;
  logic [1:0]                 out_status;
  logic [mpq_pkg::POS_W-1:0]  out_robot_row;
  logic [mpq_pkg::POS_W-1:0]  out_robot_col;
  logic [mpq_pkg::POS_W-1:0]  out_human_row;
  logic [mpq_pkg::POS_W-1:0]  out_human_col;
  logic [mpq_pkg::PRIO_W-1:0] out_priority;
  logic [mpq_pkg::FILL_W-1:0] out_fill_count;

  min_priority_queue_scan #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ROWS       (ROWS),
    .COLS       (COLS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_robot_row  (in_robot_row),
    .in_robot_col  (in_robot_col),
    .in_human_row  (in_human_row),
    .in_human_col  (in_human_col),
    .in_priority   (in_priority),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_robot_row (out_robot_row),
    .out_robot_col (out_robot_col),
    .out_human_row (out_human_row),
    .out_human_col (out_human_col),
    .out_priority  (out_priority),
    .out_fill_count(out_fill_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bench copy of the queue contents
  mpq_pkg::entry_t shadow_entries [QUEUE_DEPTH];
  int              shadow_count = 0;

  cmd_word_t    pending_cmds [$];   // words not yet taken by the block
  result_word_t expected_words [$]; // predicted results, oldest first
  int           mismatch_count = 0;

  // sender burst/gap state, owned by the driver
  int           burst_left = 0;
  int           gap_left   = 0;

  // ---------------------------------------------------------------------------
  // Queue model: apply one accepted word, push the result word it produces.
  // ---------------------------------------------------------------------------
  function automatic void apply_queue_op(input cmd_word_t w);
    result_word_t r;
    int           best;
    r = '0;
    if (w.cmd == mpq_pkg::CMD_ENQ) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = mpq_pkg::STAT_FULL;   // dropped, nothing changes
      end else begin
        shadow_entries[shadow_count] = w.ent;
        shadow_count++;
        r.status = mpq_pkg::STAT_ENQ;
      end
    end else if (shadow_count == 0) begin
      // empty: sentinel positions, zero priority
      r.status        = mpq_pkg::STAT_EMPTY;
      r.ent.robot_row = mpq_pkg::POS_W'(ROWS);
      r.ent.robot_col = mpq_pkg::POS_W'(COLS);
      r.ent.human_row = mpq_pkg::POS_W'(ROWS);
      r.ent.human_col = mpq_pkg::POS_W'(COLS);
    end else begin
      // strict less-than keeps the lowest index on a tie
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_entries[i].prio < shadow_entries[best].prio) best = i;
      end
      r.status = mpq_pkg::STAT_DEQ;
      r.ent    = shadow_entries[best];
      // last entry fills the hole
      shadow_entries[best] = shadow_entries[shadow_count-1];
      shadow_count--;
    end
    r.fill = mpq_pkg::FILL_W'(shadow_count);
    expected_words.push_back(r);
  endfunction

  // positions mostly in grid range, sometimes using all five bits;
  // priorities half full-range, half narrow so ties are common
  function automatic mpq_pkg::entry_t rand_entry();
    mpq_pkg::entry_t e;
    int              top;
    top = ($urandom_range(0, 7) == 0) ? 31 : 16;
    e.robot_row = mpq_pkg::POS_W'($urandom_range(0, top));
    e.robot_col = mpq_pkg::POS_W'($urandom_range(0, top));
    e.human_row = mpq_pkg::POS_W'($urandom_range(0, top));
    e.human_col = mpq_pkg::POS_W'($urandom_range(0, top));
    e.prio = ($urandom_range(0, 1) == 0) ? mpq_pkg::PRIO_W'($urandom)
                                         : mpq_pkg::PRIO_W'($urandom_range(0, 7));
    return e;
  endfunction

  function automatic void add_cmd(input mpq_pkg::cmd_t c, input mpq_pkg::entry_t e,
                                  input bit drain);
    cmd_word_t w;
    w.cmd        = c;
    w.ent        = e;
    w.wait_drain = drain;
    pending_cmds.push_back(w);
  endfunction

  function automatic void report_fault(input string why, input result_word_t exp_w,
                                       input result_word_t act_w);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, why);
      $display("  exp: st=%0d rr=%0d rc=%0d hr=%0d hc=%0d pr=%0d fill=%0d",
               exp_w.status, exp_w.ent.robot_row, exp_w.ent.robot_col,
               exp_w.ent.human_row, exp_w.ent.human_col, exp_w.ent.prio, exp_w.fill);
      $display("  act: st=%0d rr=%0d rc=%0d hr=%0d hc=%0d pr=%0d fill=%0d",
               act_w.status, act_w.ent.robot_row, act_w.ent.robot_col,
               act_w.ent.human_row, act_w.ent.human_col, act_w.ent.prio, act_w.fill);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A word is taken at an edge with start high and busy low; the
  // model is updated right there. start is held through busy, and each
  // signal gets a single nonblocking write per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic fire_next;
    logic drained;
    fire_next = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_queue_op(pending_cmds[0]);
        void'(pending_cmds.pop_front());
        if (burst_left != 0) burst_left--;
      end
      // a result word at this very edge may or may not be popped yet; ask for
      // an empty list with no strobe so the decision is order-independent
      drained = (expected_words.size() == 0) && !out_valid;
      if (start && busy) begin
        fire_next = 1'b1;                  // hold the word until taken
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0 &&
                   (!pending_cmds[0].wait_drain || drained)) begin
        if (burst_left == 0) begin
          // new burst; a third of bursts start with no gap at all
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
        fire_next = (gap_left == 0);
      end
      start <= fire_next;
      if (fire_next) begin
        in_command   <= pending_cmds[0].cmd;
        in_robot_row <= pending_cmds[0].ent.robot_row;
        in_robot_col <= pending_cmds[0].ent.robot_col;
        in_human_row <= pending_cmds[0].ent.human_row;
        in_human_col <= pending_cmds[0].ent.human_col;
        in_priority  <= pending_cmds[0].ent.prio;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result word is checked against the oldest one
  // predicted. The block cannot be stalled, so nothing to drive here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_word_t got;
    if (rst_n && out_valid) begin
      got = {out_status, out_robot_row, out_robot_col, out_human_row,
             out_human_col, out_priority, out_fill_count};
      if (expected_words.size() == 0) begin
        report_fault("result word with none predicted", '0, got);
      end else begin
        if (got !== expected_words[0]) report_fault("result word mismatch",
                                                    expected_words[0], got);
        void'(expected_words.pop_front());
      end
    end
  end

  // watchdog: cycles with neither a command nor a result taken
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    mpq_pkg::entry_t e;
    mpq_pkg::cmd_t   c;
    int              phase_len;
    int              enq_pct;
    int              total;

    // directed: empty dequeue, field extremes, wide bits, ties
    add_cmd(mpq_pkg::CMD_DEQ, rand_entry(), 1'b0);                     // empty
    add_cmd(mpq_pkg::CMD_ENQ, '{5'd0, 5'd0, 5'd0, 5'd0, 16'd0}, 1'b0);
    add_cmd(mpq_pkg::CMD_ENQ, '{5'd16, 5'd16, 5'd16, 5'd16, 16'hFFFF}, 1'b0);
    add_cmd(mpq_pkg::CMD_ENQ, '{5'd31, 5'd31, 5'd31, 5'd31, 16'h5A5A}, 1'b0);
    add_cmd(mpq_pkg::CMD_ENQ, '{5'd1, 5'd2, 5'd3, 5'd4, 16'd5}, 1'b0);   // three-way tie
    add_cmd(mpq_pkg::CMD_ENQ, '{5'd5, 5'd6, 5'd7, 5'd8, 16'd5}, 1'b0);
    add_cmd(mpq_pkg::CMD_ENQ, '{5'd9, 5'd10, 5'd11, 5'd12, 16'd5}, 1'b0);
    add_cmd(mpq_pkg::CMD_DEQ, '{5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF}, 1'b1);
    repeat (6) add_cmd(mpq_pkg::CMD_DEQ, rand_entry(), 1'b0);         // down to empty
    add_cmd(mpq_pkg::CMD_DEQ, '{5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF}, 1'b0);
    add_cmd(mpq_pkg::CMD_ENQ, '{5'd16, 5'd0, 5'd16, 5'd0, 16'd7}, 1'b0); // single entry
    add_cmd(mpq_pkg::CMD_DEQ, rand_entry(), 1'b0);

    // fill past full (drops), then drain past empty; starts once idle
    for (int i = 0; i < QUEUE_DEPTH + 6; i++) begin
      add_cmd(mpq_pkg::CMD_ENQ, rand_entry(), i == 0);
    end
    repeat (QUEUE_DEPTH + 2) add_cmd(mpq_pkg::CMD_DEQ, rand_entry(), 1'b0);

    // mixed phases with varying enqueue bias
    total = pending_cmds.size();
    while (total < 400) begin
      phase_len = $urandom_range(10, 40);
      case ($urandom_range(0, 3))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        2:       enq_pct = 75;
        default: enq_pct = 90;
      endcase
      repeat (phase_len) begin
        e = rand_entry();
        if ($urandom_range(1, 100) <= enq_pct) begin
          c = mpq_pkg::CMD_ENQ;
        end else begin
          c = mpq_pkg::CMD_DEQ;
        end
        add_cmd(c, e, $urandom_range(0, 39) == 0);
      end
      total += phase_len;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || expected_words.size() != 0) @(posedge clk);
    // room for a stray late word after the last expected one
    repeat (QUEUE_DEPTH + 4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
